### src/point_ellipse_distance_assert.svh
// assertion helpers for the ellipse distance block
`ifndef POINT_ELLIPSE_DISTANCE_ASSERT_SVH
`define POINT_ELLIPSE_DISTANCE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PED_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// next-cycle implication, checked outside reset
`define PED_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

### src/ped_pkg.sv
`timescale 1ns / 1ps

package ped_pkg;

  localparam int unsigned LIMB_W    = 32;
  localparam int unsigned MUL_A_W   = 96;
  localparam int unsigned MUL_B_W   = 64;
  localparam int unsigned PROD_W    = 128;
  localparam int unsigned MUL_PAIRS = 6;
  localparam int unsigned SQ_IN_W   = 68;
  localparam int unsigned SQ_RES_W  = 34;
  localparam int unsigned SQ_REM_W  = 38;
  localparam int unsigned SQ_STEPS  = 34;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = 6;

  localparam logic [31:0] AXIS_RESET = 32'h0001_0000;

  // register indexes
  localparam logic REG_MAJOR = 1'b0;
  localparam logic REG_MINOR = 1'b1;

endpackage

### src/point_ellipse_distance.sv
`timescale 1ns / 1ps
// nearest point on an axis-aligned ellipse (first quadrant) and distance to it
// input channel: in_point_u / in_point_v, valid/ready; one result word per input word
// result channel: out_nearest_u/v, out_dist_out, out_iteration_limit_hit,
//   out_axes_invalid, valid/ready
// config: apb-style write of major (addr 0) and minor (addr 4) semi-axis, q16.16
// all products, roots and quotients run on one shared 32x32 limb multiplier,
//   one radix-4 square root unit and one restoring divider,
//   sequenced by a small state machine; one word is worked on at a time
// in the general case the bisection loop (a square root plus five products per
//   iteration) sets the time from the accepting edge to out_valid
// in_ready is high only while idle, so a new word can be taken in the cycle after
//   the previous result is loaded; that word is worked on while the result waits
// when the receiver stalls, a second result waits in its last state until
//   the output register frees up
// reset (synchronous, rst_n low) empties the output register, returns to idle
//   and sets both semi-axes to 1.0
`include "point_ellipse_distance_assert.svh"

module point_ellipse_distance #(
  parameter int MAX_ITERATIONS = 64,
  parameter int COORD_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_point_u,
  input  logic [31:0] in_point_v,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_nearest_u,
  output logic [31:0] out_nearest_v,
  output logic [31:0] out_dist_out,
  output logic        out_iteration_limit_hit,
  output logic        out_axes_invalid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [31:0] CMASK = (COORD_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << COORD_WIDTH) - 64'd1);
  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [5:0] {
    ST_IDLE, ST_CHECK, ST_MUL, ST_SQRT, ST_DIV,
    ST_AA, ST_BB, ST_AU, ST_UN, ST_UQ,
    ST_AB, ST_ABSQ, ST_VA, ST_VASQ, ST_UB, ST_UBSQ,
    ST_GEN, ST_NUM, ST_ITER, ST_CX, ST_XX, ST_SQ, ST_RHS, ST_VX, ST_LHS,
    ST_EV, ST_EV1, ST_EV2, ST_EV3, ST_EV4, ST_D1, ST_D2, ST_D3, ST_DONE
  } state_t;

  state_t state_r, ret_r;

  // configuration
  logic [31:0] a_r, b_r;
  // latched word and intermediate values
  logic [31:0] u_r, v_r;
  logic [63:0] aa_r, c_r, ab_r;
  logic [95:0] num_r;
  logic [127:0] t_r;
  logic [31:0] lo_r, hi_r, mid_r;
  logic [ITER_W-1:0] iter_r;
  logic [31:0] x_r, y_r, d_r;
  logic        hit_r, inv_r;
  // output register
  logic        out_valid_r;
  logic [31:0] out_u_r, out_v_r, out_d_r;
  logic        out_hit_r, out_inv_r;

  // shared units
  logic [ped_pkg::CNT_W-1:0]    cnt_r;
  logic [ped_pkg::MUL_A_W-1:0]  mul_a_r;
  logic [ped_pkg::MUL_B_W-1:0]  mul_b_r;
  logic [ped_pkg::PROD_W-1:0]   acc_r;
  logic [63:0]                  pp_r;
  logic [1:0]                   sh_r;
  logic [ped_pkg::SQ_IN_W-1:0]  sq_in_r;
  logic [ped_pkg::SQ_REM_W-1:0] sq_rem_r;
  logic [ped_pkg::SQ_RES_W-1:0] sq_root_r;
  logic [63:0]                  dv_rem_r, dv_d_r;
  logic [31:0]                  dv_num_r, dv_q_r;

  // limb multiplier: pair k takes a-limb k mod 3 and b-limb k div 3
  logic [1:0]  mul_ia;
  logic        mul_ib;
  logic [31:0] mul_al, mul_bl;
  logic [63:0] mul_pp;
  logic [ped_pkg::PROD_W-1:0] acc_add;
  assign mul_ib = (cnt_r >= ped_pkg::CNT_W'(3));
  assign mul_ia = mul_ib ? 2'(cnt_r - ped_pkg::CNT_W'(3)) : cnt_r[1:0];
  assign mul_al = mul_a_r[32*mul_ia +: 32];
  assign mul_bl = mul_b_r[32*mul_ib +: 32];
  assign mul_pp = mul_al * mul_bl;
  assign acc_add = acc_r + (ped_pkg::PROD_W'(pp_r) << {sh_r, 5'b0});

  // square root, two radicand bits per step
  logic [ped_pkg::SQ_REM_W+1:0] sq_rem2, sq_trial, sq_diff;
  logic sq_ge;
  assign sq_rem2  = {sq_rem_r, sq_in_r[ped_pkg::SQ_IN_W-1 -: 2]};
  assign sq_trial = (ped_pkg::SQ_REM_W+2)'({sq_root_r, 2'b01});
  assign sq_ge    = (sq_rem2 >= sq_trial);
  assign sq_diff  = sq_rem2 - sq_trial;

  // divider, quotient known to fit 32 bits
  logic [64:0] dv_rem2, dv_diff;
  logic dv_ge;
  assign dv_rem2 = {dv_rem_r, dv_num_r[31]};
  assign dv_ge   = (dv_rem2 >= {1'b0, dv_d_r});
  assign dv_diff = dv_rem2 - {1'b0, dv_d_r};

  logic [31:0] mid_w, dx_w, dy_w;
  assign mid_w = lo_r + ((hi_r - lo_r) >> 1);
  assign dx_w  = (x_r > u_r) ? x_r - u_r : u_r - x_r;
  assign dy_w  = (y_r > v_r) ? y_r - v_r : v_r - y_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ped_pkg::REG_MINOR) ? b_r : a_r;

  assign in_ready                = (state_r == ST_IDLE);
  assign out_valid               = out_valid_r;
  assign out_nearest_u           = out_u_r;
  assign out_nearest_v           = out_v_r;
  assign out_dist_out            = out_d_r;
  assign out_iteration_limit_hit = out_hit_r;
  assign out_axes_invalid        = out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
      a_r         <= ped_pkg::AXIS_RESET & CMASK;
      b_r         <= ped_pkg::AXIS_RESET & CMASK;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == ped_pkg::REG_MAJOR) a_r <= pwdata & CMASK;
        else b_r <= pwdata & CMASK;
      end
      // the done state handles the output register itself
      if (out_valid_r && out_ready && state_r != ST_DONE) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            u_r     <= in_point_u & CMASK;
            v_r     <= in_point_v & CMASK;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          hit_r <= 1'b0;
          inv_r <= 1'b0;
          if (a_r == 32'd0 || b_r == 32'd0 || a_r < b_r) begin
            x_r <= '0; y_r <= '0; d_r <= '0; inv_r <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            mul_a_r <= 96'(a_r); mul_b_r <= 64'(a_r);
            acc_r <= '0; cnt_r <= '0; ret_r <= ST_AA; state_r <= ST_MUL;
          end
        end
        // shared units
        ST_MUL: begin
          if (cnt_r != '0) acc_r <= acc_add;
          if (cnt_r < ped_pkg::CNT_W'(ped_pkg::MUL_PAIRS)) begin
            pp_r <= mul_pp;
            sh_r <= 2'(mul_ia) + 2'(mul_ib);
            cnt_r <= cnt_r + 1'b1;
          end else begin
            state_r <= ret_r;
          end
        end
        ST_SQRT: begin
          sq_in_r   <= sq_in_r << 2;
          sq_rem_r  <= sq_ge ? sq_diff[ped_pkg::SQ_REM_W-1:0]
                             : sq_rem2[ped_pkg::SQ_REM_W-1:0];
          sq_root_r <= {sq_root_r[ped_pkg::SQ_RES_W-2:0], sq_ge};
          cnt_r     <= cnt_r + 1'b1;
          if (cnt_r == ped_pkg::CNT_W'(ped_pkg::SQ_STEPS - 1)) state_r <= ret_r;
        end
        ST_DIV: begin
          dv_num_r <= dv_num_r << 1;
          dv_rem_r <= dv_ge ? dv_diff[63:0] : dv_rem2[63:0];
          dv_q_r   <= {dv_q_r[30:0], dv_ge};
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == ped_pkg::CNT_W'(ped_pkg::DIV_STEPS - 1)) state_r <= ret_r;
        end
        // common products
        ST_AA: begin
          aa_r <= acc_r[63:0];
          mul_a_r <= 96'(b_r); mul_b_r <= 64'(b_r);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_BB; state_r <= ST_MUL;
        end
        ST_BB: begin
          c_r <= aa_r - acc_r[63:0];
          if (v_r == 32'd0) begin
            mul_a_r <= 96'(a_r); mul_b_r <= 64'(u_r);
            acc_r <= '0; cnt_r <= '0; ret_r <= ST_AU; state_r <= ST_MUL;
          end else if (u_r == 32'd0) begin
            // on the v axis: nearest is the top of the ellipse
            x_r <= '0; y_r <= b_r;
            d_r <= (v_r > b_r) ? v_r - b_r : b_r - v_r;
            state_r <= ST_DONE;
          end else begin
            mul_a_r <= 96'(a_r); mul_b_r <= 64'(b_r);
            acc_r <= '0; cnt_r <= '0; ret_r <= ST_AB; state_r <= ST_MUL;
          end
        end
        // on the u axis
        ST_AU: begin
          if (acc_r[63:0] < c_r) begin
            mul_a_r <= 96'(aa_r); mul_b_r <= 64'(u_r);
            acc_r <= '0; cnt_r <= '0; ret_r <= ST_UN; state_r <= ST_MUL;
          end else begin
            x_r <= a_r; y_r <= '0;
            d_r <= (u_r > a_r) ? u_r - a_r : a_r - u_r;
            state_r <= ST_DONE;
          end
        end
        ST_UN: begin
          dv_rem_r <= acc_r[95:32]; dv_num_r <= acc_r[31:0]; dv_d_r <= c_r;
          cnt_r <= '0; ret_r <= ST_UQ; state_r <= ST_DIV;
        end
        ST_UQ: begin
          x_r <= dv_q_r;
          state_r <= ST_EV;
        end
        // exact on-ellipse test
        ST_AB: begin
          ab_r <= acc_r[63:0];
          if (v_r <= b_r) begin
            mul_a_r <= 96'(acc_r[63:0]); mul_b_r <= acc_r[63:0];
            acc_r <= '0; cnt_r <= '0; ret_r <= ST_ABSQ; state_r <= ST_MUL;
          end else begin
            state_r <= ST_GEN;
          end
        end
        ST_ABSQ: begin
          t_r <= acc_r;
          mul_a_r <= 96'(v_r); mul_b_r <= 64'(a_r);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_VA; state_r <= ST_MUL;
        end
        ST_VA: begin
          mul_a_r <= 96'(acc_r[63:0]); mul_b_r <= acc_r[63:0];
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_VASQ; state_r <= ST_MUL;
        end
        ST_VASQ: begin
          t_r <= t_r - acc_r;
          mul_a_r <= 96'(u_r); mul_b_r <= 64'(b_r);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_UB; state_r <= ST_MUL;
        end
        ST_UB: begin
          mul_a_r <= 96'(acc_r[63:0]); mul_b_r <= acc_r[63:0];
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_UBSQ; state_r <= ST_MUL;
        end
        ST_UBSQ: begin
          if (acc_r == t_r) begin
            x_r <= u_r; y_r <= v_r; d_r <= '0;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_GEN;
          end
        end
        // bisection on the nearest u coordinate
        ST_GEN: begin
          mul_a_r <= 96'(aa_r); mul_b_r <= 64'(u_r);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_NUM; state_r <= ST_MUL;
        end
        ST_NUM: begin
          num_r  <= acc_r[95:0];
          lo_r   <= '0;
          hi_r   <= a_r;
          hit_r  <= 1'b1;
          iter_r <= '0;
          state_r <= ST_ITER;
        end
        ST_ITER: begin
          if (iter_r == ITER_W'(MAX_ITERATIONS)) begin
            // limit reached, keep the last midpoint
            x_r <= mid_r;
            state_r <= ST_EV;
          end else if (mid_w == lo_r || mid_w == hi_r) begin
            hit_r <= 1'b0;
            x_r <= mid_w;
            state_r <= ST_EV;
          end else begin
            mid_r <= mid_w;
            mul_a_r <= 96'(c_r); mul_b_r <= 64'(mid_w);
            acc_r <= '0; cnt_r <= '0; ret_r <= ST_CX; state_r <= ST_MUL;
          end
        end
        ST_CX: begin
          if (num_r <= acc_r[95:0]) begin
            hi_r <= mid_r;
            iter_r <= iter_r + 1'b1;
            state_r <= ST_ITER;
          end else begin
            t_r <= 128'(num_r - acc_r[95:0]);
            mul_a_r <= 96'(mid_r); mul_b_r <= 64'(mid_r);
            acc_r <= '0; cnt_r <= '0; ret_r <= ST_XX; state_r <= ST_MUL;
          end
        end
        ST_XX: begin
          sq_in_r <= ped_pkg::SQ_IN_W'(aa_r - acc_r[63:0]);
          sq_rem_r <= '0; sq_root_r <= '0;
          cnt_r <= '0; ret_r <= ST_SQ; state_r <= ST_SQRT;
        end
        ST_SQ: begin
          mul_a_r <= t_r[95:0]; mul_b_r <= 64'(sq_root_r);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_RHS; state_r <= ST_MUL;
        end
        ST_RHS: begin
          t_r <= acc_r;
          mul_a_r <= 96'(v_r); mul_b_r <= 64'(mid_r);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_VX; state_r <= ST_MUL;
        end
        ST_VX: begin
          mul_a_r <= 96'(ab_r); mul_b_r <= acc_r[63:0];
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_LHS; state_r <= ST_MUL;
        end
        ST_LHS: begin
          iter_r <= iter_r + 1'b1;
          if (acc_r > t_r) begin
            hi_r <= mid_r;
            state_r <= ST_ITER;
          end else if (acc_r < t_r) begin
            lo_r <= mid_r;
            state_r <= ST_ITER;
          end else begin
            // exact root
            hit_r <= 1'b0;
            x_r <= mid_r;
            state_r <= ST_EV;
          end
        end
        // ellipse height at x, then distance
        ST_EV: begin
          mul_a_r <= 96'(x_r); mul_b_r <= 64'(x_r);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_EV1; state_r <= ST_MUL;
        end
        ST_EV1: begin
          sq_in_r <= ped_pkg::SQ_IN_W'(aa_r - acc_r[63:0]);
          sq_rem_r <= '0; sq_root_r <= '0;
          cnt_r <= '0; ret_r <= ST_EV2; state_r <= ST_SQRT;
        end
        ST_EV2: begin
          mul_a_r <= 96'(b_r); mul_b_r <= 64'(sq_root_r);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_EV3; state_r <= ST_MUL;
        end
        ST_EV3: begin
          dv_rem_r <= acc_r[95:32]; dv_num_r <= acc_r[31:0]; dv_d_r <= 64'(a_r);
          cnt_r <= '0; ret_r <= ST_EV4; state_r <= ST_DIV;
        end
        ST_EV4: begin
          y_r <= dv_q_r;
          mul_a_r <= 96'(dx_w); mul_b_r <= 64'(dx_w);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_D1; state_r <= ST_MUL;
        end
        ST_D1: begin
          t_r <= acc_r;
          mul_a_r <= 96'(dy_w); mul_b_r <= 64'(dy_w);
          acc_r <= '0; cnt_r <= '0; ret_r <= ST_D2; state_r <= ST_MUL;
        end
        ST_D2: begin
          sq_in_r <= ped_pkg::SQ_IN_W'(t_r + acc_r);
          sq_rem_r <= '0; sq_root_r <= '0;
          cnt_r <= '0; ret_r <= ST_D3; state_r <= ST_SQRT;
        end
        ST_D3: begin
          // saturate at the largest coordinate
          d_r <= (sq_root_r > ped_pkg::SQ_RES_W'(CMASK)) ? CMASK : sq_root_r[31:0];
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_u_r   <= x_r;
            out_v_r   <= y_r;
            out_d_r   <= d_r;
            out_hit_r <= hit_r;
            out_inv_r <= inv_r;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `PED_ASSERT_IMP(a_inv_zero, out_valid_r && out_inv_r,
    out_u_r == 32'd0 && out_d_r == 32'd0 && !out_hit_r, "invalid axes with nonzero result")
  `PED_ASSERT_IMP(a_mul_cnt, state_r == ST_MUL,
    cnt_r <= ped_pkg::CNT_W'(ped_pkg::MUL_PAIRS), "limb counter overran")
  `PED_ASSERT_IMP(a_limit, state_r == ST_DONE && hit_r,
    iter_r == ITER_W'(MAX_ITERATIONS), "limit flag without full iteration count")
  `PED_ASSERT_NXT(a_start, in_valid && in_ready, state_r == ST_CHECK,
    "accepted word did not start")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

// one expected result word of the ellipse block
typedef struct packed {
  logic [31:0] nearest_u;
  logic [31:0] nearest_v;
  logic [31:0] dist_val;
  logic        limit_hit;
  logic        axes_bad;
} ellipse_result_t;

// works out the nearest ellipse point for each accepted word and checks results in order
class ellipse_scoreboard;
  bit [127:0] major_ax;
  bit [127:0] minor_ax;
  ellipse_result_t pending[$];
  int unsigned n_points;
  int unsigned n_results;
  int unsigned n_limit;
  int unsigned n_invalid;
  int unsigned n_errors;

  function new();
    major_ax = 128'd65536;
    minor_ax = 128'd65536;
  endfunction

  // floor square root, result below 2^34
  function bit [127:0] root_floor(bit [127:0] val);
    bit [127:0] r;
    bit [127:0] cand;
    r = 0;
    for (int k = 33; k >= 0; k--) begin
      cand = r | (128'd1 << k);
      if (cand * cand <= val) r = cand;
    end
    return r;
  endfunction

  function bit [127:0] height_at(bit [127:0] a, bit [127:0] b, bit [127:0] x);
    return (b * root_floor(a * a - x * x)) / a;
  endfunction

  function bit [127:0] span(bit [127:0] x, bit [127:0] y, bit [127:0] u, bit [127:0] v);
    bit [127:0] dx;
    bit [127:0] dy;
    bit [127:0] d;
    dx = x > u ? x - u : u - x;
    dy = y > v ? y - v : v - y;
    d = root_floor(dx * dx + dy * dy);
    return d > 128'hFFFF_FFFF ? 128'hFFFF_FFFF : d;
  endfunction

  // sign of the secular function at candidate x
  function int secular(bit [127:0] a, bit [127:0] b, bit [127:0] u, bit [127:0] v,
                       bit [127:0] x);
    bit [127:0] num;
    bit [127:0] cx;
    bit [127:0] rhs;
    bit [127:0] lhs;
    num = a * a * u;
    cx = (a * a - b * b) * x;
    if (num <= cx) return 1;
    rhs = (num - cx) * root_floor(a * a - x * x);
    lhs = (a * b) * (v * x);
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function void note_point(logic [31:0] pu, logic [31:0] pv);
    ellipse_result_t r;
    bit [127:0] a, b, u, v, x, y, d, c, lo, hi, mid;
    bit hit;
    int s;
    a = major_ax; b = minor_ax; u = pu; v = pv;
    x = 0; y = 0; d = 0; hit = 0;
    r = '0;
    n_points++;
    if (a == 0 || b == 0 || a < b) begin
      r.axes_bad = 1'b1;
      pending = {pending, r};
      return;
    end
    if (v > 0) begin
      if (u > 0) begin
        if (v <= b && (a * b) * (a * b) - (v * a) * (v * a) == (u * b) * (u * b)) begin
          x = u; y = v; d = 0;
        end else begin
          lo = 0; hi = a; mid = 0; hit = 1;
          for (int i = 0; i < 64; i++) begin
            mid = lo + ((hi - lo) >> 1);
            if (mid == lo || mid == hi) begin
              hit = 0;
              break;
            end
            s = secular(a, b, u, v, mid);
            if (s > 0) hi = mid;
            else if (s < 0) lo = mid;
            else begin
              hit = 0;
              break;
            end
          end
          x = mid;
          y = height_at(a, b, x);
          d = span(x, y, u, v);
        end
      end else begin
        x = 0; y = b;
        d = span(0, b, 0, v);
      end
    end else begin
      c = a * a - b * b;
      if (a * u < c) begin
        x = (a * a * u) / c;
        y = height_at(a, b, x);
        d = span(x, y, u, 0);
      end else begin
        x = a; y = 0;
        d = span(a, 0, u, 0);
      end
    end
    r.nearest_u = x[31:0];
    r.nearest_v = y[31:0];
    r.dist_val = d[31:0];
    r.limit_hit = hit;
    pending = {pending, r};
  endfunction

  function void check_result(ellipse_result_t got);
    ellipse_result_t want;
    n_results++;
    if (got.limit_hit) n_limit++;
    if (got.axes_bad) n_invalid++;
    if (pending.size() == 0) begin
      $error("result word with nothing expected");
      n_errors++;
      return;
    end
    want = pending.pop_front();
    if (got.nearest_u !== want.nearest_u) begin
      $error("nearest_u: expected %h, got %h", want.nearest_u, got.nearest_u);
      n_errors++;
    end
    if (got.nearest_v !== want.nearest_v) begin
      $error("nearest_v: expected %h, got %h", want.nearest_v, got.nearest_v);
      n_errors++;
    end
    if (got.dist_val !== want.dist_val) begin
      $error("dist_out: expected %h, got %h", want.dist_val, got.dist_val);
      n_errors++;
    end
    if (got.limit_hit !== want.limit_hit) begin
      $error("iteration_limit_hit: expected %b, got %b", want.limit_hit, got.limit_hit);
      n_errors++;
    end
    if (got.axes_bad !== want.axes_bad) begin
      $error("axes_invalid: expected %b, got %b", want.axes_bad, got.axes_bad);
      n_errors++;
    end
  endfunction
endclass

module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_point_u = '0;
  logic [31:0] in_point_v = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_nearest_u;
  logic [31:0] out_nearest_v;
  logic [31:0] out_dist_out;
  logic        out_iteration_limit_hit;
  logic        out_axes_invalid;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ellipse_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned stall_pct = 20;   // chance per cycle that the receiver holds off
  int unsigned hold_left = 0;    // cycles left in the current stall
  int unsigned n_configs = 0;

  point_ellipse_distance dut (.*);

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 40_000_000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // input side: note each accepted word in the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_point(in_point_u, in_point_v);
  end

  // result side: compare each accepted word against the oldest prediction
  always @(posedge clk) begin
    ellipse_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.nearest_u = out_nearest_u;
      got.nearest_v = out_nearest_v;
      got.dist_val = out_dist_out;
      got.limit_hit = out_iteration_limit_hit;
      got.axes_bad = out_axes_invalid;
      sb.check_result(got);
    end
  end

  // receiver backpressure, retimed at the falling edge
  always @(negedge clk) begin
    if (stall_pct == 0) begin
      out_ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      // mostly short stalls, now and then a long one
      out_ready <= 1'b0;
      hold_left <= ($urandom_range(19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    end else out_ready <= 1'b1;
  end

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic send_point(logic [31:0] u, logic [31:0] v);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_point_u = u;
    in_point_v = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // setup cycle, then access cycle; the register takes the word at the access edge
  task automatic write_axis(logic idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == ped_pkg::REG_MAJOR) sb.major_ax = val;
    else sb.minor_ax = val;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // wait for every prediction to be matched, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_axes(logic [31:0] a, logic [31:0] b);
    drain();
    write_axis(ped_pkg::REG_MAJOR, a);
    write_axis(ped_pkg::REG_MINOR, b);
    n_configs++;
  endtask

  // a point near the current ellipse, inside or outside, with random spread, or full-range noise
  task automatic send_near();
    logic [31:0] a, b, u, v;
    int unsigned p;
    a = sb.major_ax[31:0];
    b = sb.minor_ax[31:0];
    p = $urandom_range(99);
    if (p < 70) begin
      u = $urandom_range(0, (a > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : a * 2);
      v = $urandom_range(0, (b > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : b * 2);
      if ($urandom_range(9) == 0) u = 0;
      if ($urandom_range(9) == 0) v = 0;
    end else begin
      // full-range noise so every input bit toggles
      u = $urandom();
      v = $urandom();
    end
    send_point(u, v);
  endtask

  initial begin
    logic [31:0] ra, rb;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset axes (unit circle), then the special cases
    stall_pct = 0;
    send_point(32'h0, 32'h0);              // origin with a circle
    send_point(32'h0, 32'h0002_0000);      // on the v axis, outside
    send_point(32'h0, 32'h0000_8000);      // on the v axis, inside
    send_point(32'h0000_8000, 32'h0);      // on the u axis
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0001_0000, 32'h0001_0000);
    // 3-4-5 circle: points exactly on the curve
    set_axes(32'h0005_0000, 32'h0005_0000);
    send_point(32'h0003_0000, 32'h0004_0000);
    send_point(32'h0004_0000, 32'h0003_0000);
    // flattened ellipse: u axis interior and clamped branches, then the origin and general points
    set_axes(32'h0003_0000, 32'h0001_0000);
    send_point(32'h0000_4000, 32'h0);
    send_point(32'h0002_0000, 32'h0);
    send_point(32'h0005_0000, 32'h0);
    send_point(32'h0, 32'h0);
    send_point(32'h0000_0001, 32'h0000_0001);
    send_point(32'h0001_8000, 32'h0000_C000);
    // rejected axes: zero major, zero minor, major below minor
    set_axes(32'h0, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0001_0000);
    set_axes(32'h0002_0000, 32'h0);
    send_point(32'h0001_0000, 32'h0);
    set_axes(32'h0001_0000, 32'h0002_0000);
    send_point(32'h0, 32'h0001_0000);
    // largest axes, then largest major with smallest minor
    set_axes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0, 32'h0);
    send_point(32'h8000_0000, 32'h8000_0000);
    set_axes(32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h1234_5678, 32'h0000_0002);
    send_point(32'h0, 32'hFFFF_FFFF);

    // random phases, each with its own axes and receiver behavior
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: begin ra = 32'h0002_0000; rb = 32'h0001_0000; end
        1: begin ra = 32'hFFFF_FFFF; rb = 32'h0001_0000; end
        2: begin ra = 32'h0001_0000; rb = 32'h0000_0001; end
        3: begin ra = 32'h0000_4000; rb = 32'h0000_4000; end
        4: begin ra = $urandom(); rb = $urandom(); end   // may be rejected
        default: begin
          ra = $urandom_range(32'h0000_1000, 32'h0010_0000);
          rb = $urandom_range(1, ra);
        end
      endcase
      set_axes(ra, rb);
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
      for (int k = 0; k < 98; k++) send_near();
    end

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d points over %0d axis settings, %0d result words checked",
             sb.n_points, n_configs, sb.n_results);
    $display("rejected-axes results: %0d, iteration-limit results: %0d",
             sb.n_invalid, sb.n_limit);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
